// ===== rtl/core/unp_pkg.sv =====
`timescale 1ns / 1ps

package unp_pkg;

	localparam int LINE_NUMBER_WIDTH = 16;
	localparam int INDEX_WIDTH       = 8;
	localparam int BUF_W             = 40;
	localparam int HELD_W            = 6;
	localparam int HDR_BITS          = 5;
	localparam int VALUE_W           = 31;
	localparam int MAX_RESULTS       = 2;
	localparam int CNT_W             = 2;

	localparam logic [LINE_NUMBER_WIDTH-1:0] LINE_MAX  = '1;
	localparam logic [INDEX_WIDTH-1:0]       INDEX_MAX = '1;

	typedef struct packed {
		logic [BUF_W-1:0]             bit_buf;
		logic [HELD_W-1:0]            bits_held;
		logic                         header_taken;
		logic [HDR_BITS-1:0]          field_length;
		logic                         line_stopped;
		logic [INDEX_WIDTH-1:0]       integer_counter;
		logic [LINE_NUMBER_WIDTH-1:0] line_counter;
	} unp_state_t;

	typedef struct packed {
		logic [LINE_NUMBER_WIDTH-1:0] line_num;
		logic [INDEX_WIDTH-1:0]       integer_index;
		logic signed [VALUE_W-1:0]    value;
		logic                         last_of_run;
	} unp_result_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       line_end;
	} unp_item_t;

endpackage

// ===== rtl/core/unp_decode.sv =====
`timescale 1ns / 1ps

module unp_decode import unp_pkg::*; (
	input  unp_state_t                    cur,
	input  unp_item_t                     item,
	output unp_state_t                    nxt,
	output unp_result_t [MAX_RESULTS-1:0] res,
	output logic [CNT_W-1:0]              res_cnt
);

	always_comb begin
		logic [BUF_W-1:0]       b;
		logic [HELD_W-1:0]      h;
		logic                   ht;
		logic [HDR_BITS-1:0]    fl;
		logic                   st;
		logic [INDEX_WIDTH-1:0] ic;
		logic [CNT_W-1:0]       cnt;
		logic                   done;
		logic [VALUE_W-1:0]     raw;
		logic                   sx;

		b    = {cur.bit_buf[BUF_W-9:0], item.data_byte};
		h    = cur.bits_held + HELD_W'(8);
		ht   = cur.header_taken;
		fl   = cur.field_length;
		st   = cur.line_stopped;
		ic   = cur.integer_counter;
		cnt  = '0;
		done = 1'b0;
		raw  = '0;
		sx   = 1'b0;
		res  = '0;
		nxt  = cur;

		if (item.byte_present && !cur.line_stopped) begin
			// header, field, header, field, header at most
			for (int it = 0; it < 3; it++) begin
				if (!done) begin
					if (!ht) begin
						if (h < HELD_W'(HDR_BITS)) begin
							done = 1'b1;
						end else begin
							fl = HDR_BITS'(b >> (h - HELD_W'(HDR_BITS)));
							h  = h - HELD_W'(HDR_BITS);
							b  = b & ~({BUF_W{1'b1}} << h);
							if (fl == '0) begin
								st   = 1'b1;
								b    = '0;
								h    = '0;
								done = 1'b1;
							end else begin
								ht = 1'b1;
							end
						end
					end
					if (!done) begin
						if (h < HELD_W'(fl) || cnt == CNT_W'(MAX_RESULTS)) begin
							done = 1'b1;
						end else begin
							raw = VALUE_W'(b >> (h - HELD_W'(fl)))
								& ~({VALUE_W{1'b1}} << fl);
							h   = h - HELD_W'(fl);
							b   = b & ~({BUF_W{1'b1}} << h);
							sx  = raw[HDR_BITS'(fl - HDR_BITS'(1))];
							if (sx) begin
								raw = raw | ({VALUE_W{1'b1}} << fl);
							end
							res[cnt[0]].line_num      = cur.line_counter;
							res[cnt[0]].integer_index = ic;
							res[cnt[0]].value         = raw;
							cnt = cnt + CNT_W'(1);
							ht  = 1'b0;
							fl  = '0;
							if (ic != INDEX_MAX) begin
								ic = ic + INDEX_WIDTH'(1);
							end
						end
					end
				end
			end
			nxt.bit_buf         = b;
			nxt.bits_held       = h;
			nxt.header_taken    = ht;
			nxt.field_length    = fl;
			nxt.line_stopped    = st;
			nxt.integer_counter = ic;
		end

		if (cnt == CNT_W'(1)) begin
			res[0].last_of_run = 1'b1;
		end else if (cnt == CNT_W'(2)) begin
			res[1].last_of_run = 1'b1;
		end
		res_cnt = cnt;

		if (item.line_end) begin
			nxt.bit_buf         = '0;
			nxt.bits_held       = '0;
			nxt.header_taken    = 1'b0;
			nxt.field_length    = '0;
			nxt.line_stopped    = 1'b0;
			nxt.integer_counter = INDEX_WIDTH'(1);
			if (cur.line_counter != LINE_MAX) begin
				nxt.line_counter = cur.line_counter + LINE_NUMBER_WIDTH'(1);
			end
		end
	end

endmodule

// ===== rtl/core/length_prefixed_signed_unpacker_core.sv =====
`timescale 1ns / 1ps
// Channel   Dir  tdata                                          tuser         tlast
// s_axis    in   [7:0] data_byte                                byte_present  line_end
// m_axis    out  [15:0] line_num, [23:16] integer_index,        -             last_of_run
//                [54:24] value, [55] zero
// One byte transaction per cycle unless stalled; items decode from the input register.
// An item with two results holds the result register until both are taken.
// Throughput is set by the two-slot result register, one result a cycle while ready.
// arst_n clears valid, decode state, result count; line/integer counters restart at 1.
// A stalled output holds the input register; one more transaction may wait there.

module length_prefixed_signed_unpacker_core import unp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] byte_present
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // [15:0] line_num, [23:16] integer_index,
	                                   // [54:24] value, [55] zero
	output logic        m_axis_tlast
);

	unp_item_t                     item_s1;
	logic                          valid_s1;
	unp_state_t                    st_q;
	unp_state_t                    st_nxt;
	unp_result_t [MAX_RESULTS-1:0] res_s2;
	logic [CNT_W-1:0]              res_cnt_s2;
	unp_result_t [MAX_RESULTS-1:0] dec_res;
	logic [CNT_W-1:0]              dec_cnt;
	logic                          pop;
	logic                          adv;

	unp_decode u_decode (
		.cur     (st_q),
		.item    (item_s1),
		.nxt     (st_nxt),
		.res     (dec_res),
		.res_cnt (dec_cnt)
	);

	assign pop = m_axis_tvalid && m_axis_tready;
	assign adv = valid_s1 && (res_cnt_s2 == '0 || (res_cnt_s2 == CNT_W'(1) && pop));
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= '{data_byte: s_axis_tdata, byte_present: s_axis_tuser,
				line_end: s_axis_tlast};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{bit_buf: '0, bits_held: '0, header_taken: 1'b0, field_length: '0,
				line_stopped: 1'b0, integer_counter: INDEX_WIDTH'(1),
				line_counter: LINE_NUMBER_WIDTH'(1)};
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_s2 <= '0;
		end else if (adv) begin
			res_cnt_s2 <= dec_cnt;
		end else if (pop) begin
			res_cnt_s2 <= res_cnt_s2 - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= dec_res;
		end else if (pop) begin
			res_s2[0] <= res_s2[1];
		end
	end

	assign m_axis_tvalid = res_cnt_s2 != '0;
	assign m_axis_tdata  = {1'b0, res_s2[0].value, res_s2[0].integer_index,
		res_s2[0].line_num};
	assign m_axis_tlast  = res_s2[0].last_of_run;

`ifndef SYNTH
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bits_held <= HELD_W'(BUF_W - 2))
		else $error("bit buffer overfilled");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_s2 <= CNT_W'(MAX_RESULTS))
		else $error("result count out of range");

	a_stop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.line_stopped |-> st_q.bits_held == '0 && !st_q.header_taken)
		else $error("stopped line still holds bits");

	a_line_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.line_end |=> st_q.integer_counter == INDEX_WIDTH'(1)
			&& st_q.bits_held == '0 && !st_q.line_stopped)
		else $error("line end did not clear line state");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_s2 == CNT_W'(1) |-> m_axis_tlast)
		else $error("final result of a transaction not marked last");
`endif

endmodule

// ===== bench/length_prefixed_signed_unpacker_core_tb.sv =====
`timescale 1ns / 1ps

module length_prefixed_signed_unpacker_core_tb;
	import unp_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned RANDOM_ITEMS = 910;
	localparam int unsigned SETTLE       = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tlast;

	length_prefixed_signed_unpacker_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #4 clk = ~clk;

	// decoder mirror
	logic [63:0]                  bit_store = '0;
	int unsigned                  held_bits = 0;
	bit                           length_read = 1'b0;
	int unsigned                  cur_length = 0;
	bit                           stopped = 1'b0;
	logic [INDEX_WIDTH-1:0]       index_count = INDEX_WIDTH'(1);
	logic [LINE_NUMBER_WIDTH-1:0] line_count = LINE_NUMBER_WIDTH'(1);

	unp_result_t pending_results[$];
	bit          field_bits[$];

	int unsigned failures = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned lines_closed = 0;
	int unsigned cycles = 0;
	int unsigned hold_trigger = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	bit          send_idle = 1'b1;
	bit          sink_idle = 1'b1;
	bit          noise_on = 1'b0;

	function automatic logic [63:0] pull_bits(int unsigned n);
		logic [63:0] v;
		v = (bit_store >> (held_bits - n)) & ((64'd1 << n) - 64'd1);
		held_bits = held_bits - n;
		bit_store = bit_store & ((64'd1 << held_bits) - 64'd1);
		return v;
	endfunction

	function automatic void decode_item(logic [7:0] data, logic present, logic close);
		unp_result_t found[2];
		int unsigned n;
		logic [63:0] v;
		n = 0;
		if (present && !stopped) begin
			bit_store = ((bit_store << 8) | {56'd0, data}) & ((64'd1 << BUF_W) - 64'd1);
			held_bits = held_bits + 8;
			while (1) begin
				if (!length_read) begin
					if (held_bits < HDR_BITS)
						break;
					cur_length = 32'(pull_bits(HDR_BITS));
					if (cur_length == 0) begin
						stopped = 1'b1;
						bit_store = '0;
						held_bits = 0;
						break;
					end
					length_read = 1'b1;
				end
				if (held_bits < cur_length || n >= MAX_RESULTS)
					break;
				v = pull_bits(cur_length);
				if (v[cur_length - 1])
					v = v | ~((64'd1 << cur_length) - 64'd1);
				found[n].line_num      = line_count;
				found[n].integer_index = index_count;
				found[n].value         = v[VALUE_W-1:0];
				found[n].last_of_run   = 1'b0;
				n++;
				length_read = 1'b0;
				cur_length = 0;
				if (index_count != INDEX_MAX)
					index_count++;
			end
		end
		if (n > 0)
			found[n-1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			pending_results.push_back(found[i]);
		if (close) begin
			bit_store = '0;
			held_bits = 0;
			length_read = 1'b0;
			cur_length = 0;
			stopped = 1'b0;
			index_count = INDEX_WIDTH'(1);
			if (line_count != LINE_MAX)
				line_count++;
			lines_closed++;
		end
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_seen != hold_trigger) begin
			hold_seen = hold_trigger;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(sink_idle && $urandom_range(99) < 34);
		end
	end

	always @(posedge clk) begin
		unp_result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result transaction, tdata %h", m_axis_tdata);
				failures++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_axis_tdata[15:0] !== exp_r.line_num) begin
					$error("line_num: expected %0d, got %0d",
						exp_r.line_num, m_axis_tdata[15:0]);
					failures++;
				end
				if (m_axis_tdata[23:16] !== exp_r.integer_index) begin
					$error("integer_index: expected %0d, got %0d",
						exp_r.integer_index, m_axis_tdata[23:16]);
					failures++;
				end
				if (m_axis_tdata[54:24] !== exp_r.value) begin
					$error("value: expected %0d, got %0d",
						exp_r.value, $signed(m_axis_tdata[54:24]));
					failures++;
				end
				if (m_axis_tlast !== exp_r.last_of_run) begin
					$error("last_of_run: expected %0d, got %0d",
						exp_r.last_of_run, m_axis_tlast);
					failures++;
				end
				if (m_axis_tdata[55] !== 1'b0) begin
					$error("pad: expected 0, got %0d", m_axis_tdata[55]);
					failures++;
				end
			end
		end
	end

	task automatic send_item(input logic [7:0] data, input logic present, input logic close);
		while (send_idle && $urandom_range(99) < 34) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'($urandom);
			s_axis_tuser  <= 1'($urandom);
			s_axis_tlast  <= 1'($urandom);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= present;
		s_axis_tlast  <= close;
		do @(posedge clk); while (!s_axis_tready);
		decode_item(data, present, close);
		if (present || close)
			items_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic add_field(input int unsigned len, input int unsigned val);
		for (int i = 4; i >= 0; i--)
			field_bits.push_back(len[i]);
		for (int i = int'(len) - 1; i >= 0; i--)
			field_bits.push_back(val[i]);
	endtask

	// packs queued bits MSB first, random padding in the last byte
	task automatic flush_bits(input bit close);
		logic [7:0] b;
		if (field_bits.size() == 0 && close)
			send_item(8'($urandom), 1'b0, 1'b1);
		while (field_bits.size() != 0) begin
			b = 8'($urandom);
			for (int i = 7; i >= 0; i--)
				if (field_bits.size() != 0)
					b[i] = field_bits.pop_front();
			if (noise_on && $urandom_range(99) < 3)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(b, 1'b1, close && field_bits.size() == 0);
		end
	endtask

	task automatic test_extremes();
		add_field(1, 0);
		add_field(1, 1);
		add_field(1, 1);
		add_field(1, 0);
		add_field(31, 32'h3FFF_FFFF);
		add_field(31, 32'h4000_0000);
		add_field(31, 32'h7FFF_FFFF);
		add_field(2, 2);
		add_field(0, 0);
		flush_bits(1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
	endtask

	task automatic test_line_edges();
		add_field(20, 32'h5_A5A5);
		repeat (20) void'(field_bits.pop_back());
		flush_bits(1'b1);
		send_item(8'hA5, 1'b0, 1'b0);
		send_item(8'h5A, 1'b0, 1'b1);
		add_field(3, 3);
		add_field(7, 32'h40);
		flush_bits(1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
	endtask

	task automatic test_index_saturation();
		for (int i = 0; i < 262; i++)
			add_field($urandom_range(1, 2), $urandom);
		flush_bits(1'b1);
	endtask

	task automatic random_line();
		int unsigned r;
		int unsigned nf;
		int unsigned n;
		int unsigned len;
		r = $urandom_range(99);
		if (r < 8) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				send_item(8'($urandom), 1'b1, i == n - 1);
		end else if (r < 12) begin
			send_item(8'($urandom), 1'b0, 1'b1);
		end else begin
			nf = $urandom_range(1, 6);
			for (int i = 0; i < nf; i++) begin
				len = ($urandom_range(99) < 70) ? $urandom_range(1, 8) : $urandom_range(1, 31);
				add_field(len, $urandom);
			end
			r = $urandom_range(99);
			if (r < 35) begin
				add_field(0, 0);
				n = $urandom_range(0, 20);
				repeat (n) field_bits.push_back(1'($urandom));
			end else if (r < 65) begin
				len = $urandom_range(1, 31);
				add_field(len, $urandom);
				n = $urandom_range(1, len);
				repeat (n) void'(field_bits.pop_back());
			end
			if ($urandom_range(99) < 85) begin
				flush_bits(1'b1);
			end else begin
				flush_bits(1'b0);
				send_item(8'($urandom), 1'b0, 1'b1);
			end
		end
	endtask

	task automatic test_random_lines();
		int unsigned start;
		bit held;
		bit paused;
		start = items_sent;
		held = 1'b0;
		paused = 1'b0;
		noise_on = 1'b1;
		while (items_sent - start < RANDOM_ITEMS) begin
			send_idle = (items_sent - start < 150) || (items_sent - start > 350);
			sink_idle = send_idle;
			if (!held && items_sent - start >= 450) begin
				held = 1'b1;
				hold_trigger++;
			end
			if (!paused && items_sent - start >= 800) begin
				paused = 1'b1;
				drain_results();
			end
			random_line();
		end
		noise_on = 1'b0;
		send_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_line_edges();
		test_index_saturation();
		test_random_lines();
		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results still outstanding", pending_results.size());
			failures++;
		end
		$display("Sent %0d input transactions over %0d lines, checked %0d results",
			items_sent, lines_closed, results_seen);
		$display("Covered stop headers, cut-off fields, empty lines and index saturation");
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/unp_pkg.sv
rtl/core/unp_decode.sv
rtl/core/length_prefixed_signed_unpacker_core.sv
bench/length_prefixed_signed_unpacker_core_tb.sv
